@@ design/wts_pkg.sv @@
// wts_pkg: widths, limits and register indexes of the wrapped texture sampler
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none
package wts_pkg;
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DIM_W      = 9;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = FRAC_W + DIM_W;
  localparam int ADDR_W     = 16;
  localparam int TEXEL_W    = 32;
  localparam int COORD_W    = 32;
  localparam int CH_W       = 8;
  localparam int WT_W       = 9;
  localparam int CFG_IDX_W  = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_TEX_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_TEX_HEIGHT = 2'd1;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;
endpackage
`default_nettype wire

@@ design/wts_if.sv @@
// wts_in_if / wts_out_if: valid-ready channels for sample requests and colours
// depends on wts_pkg
`timescale 1ns / 1ps
`default_nettype none
interface wts_in_if;
  import wts_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [ADDR_W-1:0]         texel_index;
  logic [TEXEL_W-1:0]        texel_value;
  logic signed [COORD_W-1:0] coord_u;
  logic signed [COORD_W-1:0] coord_v;
  logic                      filter_bilinear;
  modport source (output valid, mode, texel_index, texel_value, coord_u, coord_v,
                  filter_bilinear, input ready);
  modport sink (input valid, mode, texel_index, texel_value, coord_u, coord_v,
                filter_bilinear, output ready);
endinterface

interface wts_out_if;
  import wts_pkg::*;
  logic               valid;
  logic               ready;
  logic [TEXEL_W-1:0] color;
  modport source (output valid, color, input ready);
  modport sink (input valid, color, output ready);
endinterface
`default_nettype wire

@@ design/wrapped_texture_sampler.sv @@
// wrapped_texture_sampler: texel store with nearest and bilinear sampling
// depends on wts_pkg and the channel interfaces in wts_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Six-stage pipeline taking one beat per clock unless the output stalls: a
// texel write or a sample request may enter in every unstalled cycle. Four
// replicas of the 64k x 32 texel store, each written by every texel write and
// each read at one of the four neighbour addresses, let a bilinear sample
// fetch its whole 2x2 footprint in the read stage. Writes land in the store at
// the read stage, so they take effect in beat order. A stalled output freezes
// the whole pipeline. No clearing pass: unwritten texels read as junk.
module wrapped_texture_sampler (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire [wts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [wts_pkg::DIM_W-1:0]     cfg_wdata,
  wts_in_if.sink                       in_ch,
  wts_out_if.source                    out_ch
);
  import wts_pkg::*;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [TEXEL_W-1:0] texel_t;
  typedef logic [DIM_W-1:0]   dim_t;

  function automatic logic [CH_W-1:0] lerp8(input logic [CH_W-1:0] c0,
                                            input logic [CH_W-1:0] c1,
                                            input logic [WT_W-1:0] s);
    logic [CH_W+WT_W-1:0] acc;
    acc = (CH_W+WT_W)'(c0) * (CH_W+WT_W)'(WT_W'(256) - s)
        + (CH_W+WT_W)'(c1) * (CH_W+WT_W)'(s) + (CH_W+WT_W)'(128);
    return acc[CH_W+WT_W-2:CH_W];
  endfunction

  dim_t tex_width_r, tex_height_r, w_sat, h_sat;
  logic adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= '0;
      tex_height_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEX_WIDTH:  tex_width_r  <= cfg_wdata;
        REG_TEX_HEIGHT: tex_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign w_sat = (tex_width_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : tex_width_r;
  assign h_sat = (tex_height_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : tex_height_r;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_v_r;
  logic m1_r, m2_r, m3_r, m4_r, m5_r;
  logic b1_r, b2_r, b3_r, b4_r, b5_r;
  logic z1_r, z2_r, z3_r, z4_r, z5_r;

  // stage 1: wrap, pick scale factors
  logic [FRAC_W-1:0] fu1_r, fv1_r;
  dim_t wm1_r, hm1_r, w1_r, h1_r;
  addr_t idx1_r, idx2_r;
  texel_t val1_r, val2_r, val3_r;
  // stage 2: scaled coordinates
  logic [PROD_W-1:0] xf2_r, yf2_r;
  dim_t w2_r, h2_r;
  // stage 3: neighbour addresses and weights
  addr_t a00_r, a10_r, a01_r, a11_r;
  logic [WT_W-1:0] sx3_r, sy3_r, sx4_r, sy4_r, sy5_r;
  // stage 4: texel reads
  texel_t q00_r, q10_r, q01_r, q11_r, q5_r;
  // stage 5: horizontal blend
  logic [TEXEL_W-1:0] top5_r, bot5_r;
  texel_t color_r;

  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; out_v_r <= 1'b0;
    end else if (adv) begin
      v1_r    <= in_ch.valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      out_v_r <= v5_r && (m5_r == MODE_SAMPLE);
    end
  end

  // stage 2 and 3 combinational terms
  dim_t x0, y0, x1, y1;
  logic [DIM_W:0] x0p, y0p;
  logic [2*DIM_W-1:0] r0, r1;
  logic [FRAC_W:0] sxr, syr;

  assign x0  = xf2_r[PROD_W-1:FRAC_W];
  assign y0  = yf2_r[PROD_W-1:FRAC_W];
  assign x0p = {1'b0, x0} + (DIM_W+1)'(1);
  assign y0p = {1'b0, y0} + (DIM_W+1)'(1);
  assign x1  = (x0p >= {1'b0, w2_r}) ? DIM_W'(w2_r - DIM_W'(1)) : x0p[DIM_W-1:0];
  assign y1  = (y0p >= {1'b0, h2_r}) ? DIM_W'(h2_r - DIM_W'(1)) : y0p[DIM_W-1:0];
  assign r0  = (2*DIM_W)'(y0) * (2*DIM_W)'(w2_r);
  assign r1  = (2*DIM_W)'(y1) * (2*DIM_W)'(w2_r);
  assign sxr = {1'b0, xf2_r[FRAC_W-1:0]} + (FRAC_W+1)'(128);
  assign syr = {1'b0, yf2_r[FRAC_W-1:0]} + (FRAC_W+1)'(128);

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      m1_r   <= in_ch.mode;
      b1_r   <= in_ch.filter_bilinear;
      fu1_r  <= in_ch.coord_u[FRAC_W-1:0];
      fv1_r  <= in_ch.coord_v[FRAC_W-1:0];
      z1_r   <= (w_sat == '0) || (h_sat == '0);
      wm1_r  <= in_ch.filter_bilinear ? DIM_W'(w_sat - DIM_W'(1)) : w_sat;
      hm1_r  <= in_ch.filter_bilinear ? DIM_W'(h_sat - DIM_W'(1)) : h_sat;
      w1_r   <= w_sat;
      h1_r   <= h_sat;
      idx1_r <= in_ch.texel_index;
      val1_r <= in_ch.texel_value;
      // stage 2
      m2_r   <= m1_r; b2_r <= b1_r; z2_r <= z1_r;
      xf2_r  <= PROD_W'(fu1_r) * PROD_W'(wm1_r);
      yf2_r  <= PROD_W'(fv1_r) * PROD_W'(hm1_r);
      w2_r   <= w1_r;
      h2_r   <= h1_r;
      idx2_r <= idx1_r;
      val2_r <= val1_r;
      // stage 3
      m3_r   <= m2_r; b3_r <= b2_r; z3_r <= z2_r;
      val3_r <= val2_r;
      sx3_r  <= sxr[FRAC_W:8];
      sy3_r  <= syr[FRAC_W:8];
      if (m2_r == MODE_WRITE) begin
        a00_r <= idx2_r;
      end else begin
        a00_r <= ADDR_W'(r0 + (2*DIM_W)'(x0));
      end
      a10_r  <= ADDR_W'(r0 + (2*DIM_W)'(x1));
      a01_r  <= ADDR_W'(r1 + (2*DIM_W)'(x0));
      a11_r  <= ADDR_W'(r1 + (2*DIM_W)'(x1));
      // stage 4 control
      m4_r   <= m3_r; b4_r <= b3_r; z4_r <= z3_r;
      sy4_r  <= sy3_r;
      // stage 5: horizontal blend per channel
      m5_r   <= m4_r; b5_r <= b4_r; z5_r <= z4_r;
      sy5_r  <= sy4_r;
      q5_r   <= q00_r;
      for (int c = 0; c < TEXEL_W / CH_W; c++) begin
        top5_r[c*CH_W +: CH_W] <= lerp8(q00_r[c*CH_W +: CH_W], q10_r[c*CH_W +: CH_W],
                                        sx4_r);
        bot5_r[c*CH_W +: CH_W] <= lerp8(q01_r[c*CH_W +: CH_W], q11_r[c*CH_W +: CH_W],
                                        sx4_r);
      end
      // stage 6: vertical blend, nearest texel or zero, output register
      if (z5_r) begin
        color_r <= '0;
      end else if (!b5_r) begin
        color_r <= q5_r;
      end else begin
        for (int c = 0; c < TEXEL_W / CH_W; c++) begin
          color_r[c*CH_W +: CH_W] <= lerp8(top5_r[c*CH_W +: CH_W],
                                           bot5_r[c*CH_W +: CH_W], sy5_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx4_r <= sx3_r;
    end
  end

  // texel store replicas, one read port each; writes go to all four
  texel_t mem00 [1 << ADDR_W];
  texel_t mem10 [1 << ADDR_W];
  texel_t mem01 [1 << ADDR_W];
  texel_t mem11 [1 << ADDR_W];
  logic wr_en;
  assign wr_en = adv && v3_r && (m3_r == MODE_WRITE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem00[a00_r] <= val3_r;
      mem10[a00_r] <= val3_r;
      mem01[a00_r] <= val3_r;
      mem11[a00_r] <= val3_r;
    end
    if (adv) begin
      q00_r <= mem00[a00_r];
      q10_r <= mem10[a10_r];
      q01_r <= mem01[a01_r];
      q11_r <= mem11[a11_r];
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.color = color_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({v1_r, v2_r, v3_r, v4_r, v5_r, out_v_r}))
    else $error("pipeline valid bits moved during a stall");
  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (sx3_r <= WT_W'(256)) && (sy3_r <= WT_W'(256)))
    else $error("blend weight above 256");
  a_nearest_col: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && (m2_r == MODE_SAMPLE) && !b2_r && !z2_r |-> x0 < w2_r)
    else $error("nearest column beyond width");
  a_write_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v5_r && (m5_r == MODE_WRITE) |=> !out_v_r)
    else $error("texel write produced an output beat");
endmodule
`default_nettype wire

@@ tb/sv/wrapped_texture_sampler_tb.sv @@
// wrapped_texture_sampler_tb: directed table then random texel writes and samples,
// with every colour checked against a typed value or an in-bench predictor of the sampler
// depends on wts_pkg, wts_if.sv and the wrapped_texture_sampler top level
`timescale 1ns / 1ps
module wrapped_texture_sampler_tb;
  import wts_pkg::*;

  typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;
  typedef struct {
    row_kind_t   kind;
    logic        mode;
    logic [15:0] idx;
    logic [31:0] val;
    logic [31:0] u;
    logic [31:0] v;
    logic        bil;
    bit          typed;
    logic [31:0] colour;
  } row_t;

  localparam cfg_idx_t REG_UNUSED = 2'd2;
  localparam int DRAIN_CYCLES = 12;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_wdata;

  wts_in_if  in_ch ();
  wts_out_if out_ch ();

  wrapped_texture_sampler u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
  );

  // predictor state
  bit [31:0] texel_mem [65536];
  bit        texel_known [65536];
  bit [8:0]  dim_w;
  bit [8:0]  dim_h;
  bit [31:0] colour_due [$];

  row_t rows [$];
  int   idle_pct;
  int   stall_pct;
  bit   hold_req;
  int   hold_cnt;
  int   errors;
  int   items_sent;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // texel addresses of the footprint and the Q8 weights; nearest uses a[0] with zero weights
  task automatic footprint(input bit [15:0] fu, input bit [15:0] fv, input bit bil,
                           output bit [15:0] a [4], output bit [31:0] sx,
                           output bit [31:0] sy, output bit no_image);
    bit [31:0] w, h, x0, y0, x1, y1, xf, yf, r0, r1;
    w = (dim_w > MAX_WIDTH) ? MAX_WIDTH : dim_w;
    h = (dim_h > MAX_HEIGHT) ? MAX_HEIGHT : dim_h;
    no_image = (w == 0 || h == 0);
    sx = 0;
    sy = 0;
    for (int i = 0; i < 4; i++) a[i] = 0;
    if (!no_image) begin
      if (!bil) begin
        x0 = (fu * w) >> 16;
        y0 = (fv * h) >> 16;
        for (int i = 0; i < 4; i++) a[i] = y0 * w + x0;
      end else begin
        xf = fu * (w - 1);
        yf = fv * (h - 1);
        x0 = xf >> 16;
        y0 = yf >> 16;
        x1 = (x0 + 1 > w - 1) ? w - 1 : x0 + 1;
        y1 = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;
        sx = ((xf & 32'hFFFF) + 128) >> 8;
        sy = ((yf & 32'hFFFF) + 128) >> 8;
        r0 = y0 * w;
        r1 = y1 * w;
        a[0] = r0 + x0;
        a[1] = r0 + x1;
        a[2] = r1 + x0;
        a[3] = r1 + x1;
      end
    end
  endtask

  function automatic bit [31:0] blend_ch(bit [31:0] c0, bit [31:0] c1, bit [31:0] s);
    return (c0 * (256 - s) + c1 * s + 128) >> 8;
  endfunction

  task automatic predict_colour(input bit [15:0] fu, input bit [15:0] fv, input bit bil,
                                output bit [31:0] colour);
    bit [15:0] a [4];
    bit [31:0] sx, sy, top, bot;
    bit no_image;
    footprint(fu, fv, bil, a, sx, sy, no_image);
    colour = 0;
    if (!no_image)
      for (int sh = 0; sh < 32; sh += 8) begin
        top = blend_ch((texel_mem[a[0]] >> sh) & 8'hFF, (texel_mem[a[1]] >> sh) & 8'hFF, sx);
        bot = blend_ch((texel_mem[a[2]] >> sh) & 8'hFF, (texel_mem[a[3]] >> sh) & 8'hFF, sx);
        colour |= (blend_ch(top, bot, sy) & 8'hFF) << sh;
      end
  endtask

  // drive one beat from the falling edge, hold until accepted, then update the predictor
  task automatic send_beat(input logic mode, input logic [15:0] idx, input logic [31:0] val,
                           input logic [31:0] u, input logic [31:0] v, input logic bil,
                           input bit typed, input logic [31:0] typed_colour);
    bit [31:0] colour;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.mode = mode;
    in_ch.texel_index = idx;
    in_ch.texel_value = val;
    in_ch.coord_u = u;
    in_ch.coord_v = v;
    in_ch.filter_bilinear = bil;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (mode == MODE_WRITE) begin
      texel_mem[idx] = val;
      texel_known[idx] = 1'b1;
    end else begin
      predict_colour(u[15:0], v[15:0], bil, colour);
      colour_due.push_back(typed ? typed_colour : colour);
    end
    items_sent++;
    @(negedge clk);
  endtask

  // a sample whose footprint touches unwritten texels gets those texels written first
  task automatic send_sample(input logic [31:0] u, input logic [31:0] v, input logic bil,
                             input bit typed, input logic [31:0] typed_colour);
    bit [15:0] a [4];
    bit [31:0] sx, sy;
    bit no_image;
    footprint(u[15:0], v[15:0], bil, a, sx, sy, no_image);
    if (!no_image)
      for (int i = 0; i < 4; i++)
        if (!texel_known[a[i]])
          send_beat(MODE_WRITE, a[i], $urandom, $urandom, $urandom, $urandom_range(1),
                    0, 0);
    send_beat(MODE_SAMPLE, $urandom, $urandom, u, v, bil, typed, typed_colour);
  endtask

  task automatic settle();
    int guard;
    in_ch.valid = 1'b0;
    guard = 0;
    while (colour_due.size() != 0 && guard < 200_000) begin
      @(negedge clk);
      guard++;
    end
    if (colour_due.size() != 0) begin
      $display("FAILED: results differ");
      $finish;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t index, input logic [8:0] data);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (index == REG_TEX_WIDTH) dim_w = data;
    else if (index == REG_TEX_HEIGHT) dim_h = data;
  endtask

  task automatic set_dims(input logic [8:0] w, input logic [8:0] h);
    settle();
    write_reg(REG_TEX_WIDTH, w);
    write_reg(REG_TEX_HEIGHT, h);
  endtask

  function automatic row_t cfg_row(cfg_idx_t index, logic [8:0] data);
    row_t r;
    r = '{ROW_CFG, MODE_WRITE, index, data, 0, 0, 0, 0, 0};
    return r;
  endfunction

  function automatic row_t item_row(logic mode, logic [15:0] idx, logic [31:0] val,
                                    logic [31:0] u, logic [31:0] v, logic bil,
                                    bit typed, logic [31:0] colour);
    row_t r;
    r = '{ROW_ITEM, mode, idx, val, u, v, bil, typed, colour};
    return r;
  endfunction

  // receiver ready, with one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        out_ch.ready = 1'b0;
        hold_cnt--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (colour_due.size() == 0) begin
          $display("%0t: unexpected colour beat: expected none, actual %08h",
                   $realtime, out_ch.color);
          errors++;
        end else begin
          if (out_ch.color !== colour_due[0]) begin
            $display("%0t: colour mismatch: expected %08h, actual %08h",
                     $realtime, colour_due[0], out_ch.color);
            errors++;
          end
          void'(colour_due.pop_front());
        end
      end
    end
  end

  initial begin
    logic [31:0] u, v;
    int sel, phase_items;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_WRITE;
    in_ch.texel_index = '0;
    in_ch.texel_value = '0;
    in_ch.coord_u = '0;
    in_ch.coord_v = '0;
    in_ch.filter_bilinear = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    errors = 0;
    items_sent = 0;
    dim_w = 0;
    dim_h = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // no image after reset reads zero
    rows.push_back(item_row(MODE_SAMPLE, 16'hFFFF, 32'hFFFFFFFF, 0, 0, 0, 1, 0));
    rows.push_back(item_row(MODE_SAMPLE, 0, 0, 32'h7FFFFFFF, 32'h80000000, 1, 1, 0));
    rows.push_back(cfg_row(REG_TEX_WIDTH, 9'd2));
    rows.push_back(cfg_row(REG_TEX_HEIGHT, 9'd2));
    rows.push_back(item_row(MODE_WRITE, 0, 32'h00000000, 32'hFFFFFFFF, 0, 1, 0, 0));
    rows.push_back(item_row(MODE_WRITE, 1, 32'hFFFFFFFF, 0, 32'hFFFFFFFF, 0, 0, 0));
    rows.push_back(item_row(MODE_WRITE, 2, 32'h12345678, 0, 0, 1, 0, 0));
    rows.push_back(item_row(MODE_WRITE, 3, 32'hA5C3F00F, 0, 0, 0, 0, 0));
    rows.push_back(item_row(MODE_SAMPLE, 16'hFFFF, 32'hFFFFFFFF, 0, 0, 0, 1, 32'h00000000));
    rows.push_back(item_row(MODE_SAMPLE, 0, 0, 32'h00008000, 0, 0, 1, 32'hFFFFFFFF));
    // negative coordinates wrap to the top fraction
    rows.push_back(item_row(MODE_SAMPLE, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 1,
                            32'hA5C3F00F));
    rows.push_back(item_row(MODE_SAMPLE, 0, 0, 32'h80000000, 32'h7FFF0000, 0, 1, 0));
    rows.push_back(item_row(MODE_SAMPLE, 0, 0, 0, 0, 1, 1, 32'h00000000));
    rows.push_back(item_row(MODE_SAMPLE, 0, 0, 32'h00008000, 32'h00008000, 1, 0, 0));
    rows.push_back(item_row(MODE_SAMPLE, 0, 0, 32'hFFFFFFFF, 32'h7FFFFFFF, 1, 0, 0));
    rows.push_back(item_row(MODE_SAMPLE, 0, 0, 32'hFFFF4000, 32'h00010000, 1, 0, 0));
    // write to an index past the register list leaves the dimensions alone
    rows.push_back(cfg_row(REG_UNUSED, 9'h1FF));
    rows.push_back(item_row(MODE_SAMPLE, 0, 0, 32'h00010000, 32'hFFFF0000, 0, 1, 0));
    // one texel wide, oversized height saturates
    rows.push_back(cfg_row(REG_TEX_WIDTH, 9'd1));
    rows.push_back(cfg_row(REG_TEX_HEIGHT, 9'h1FF));
    rows.push_back(item_row(MODE_SAMPLE, 0, 0, 32'h1234C000, 32'hFFFFFFFF, 1, 0, 0));
    rows.push_back(item_row(MODE_SAMPLE, 0, 0, 0, 32'h00008080, 0, 0, 0));
    rows.push_back(cfg_row(REG_TEX_WIDTH, 9'h100));
    rows.push_back(cfg_row(REG_TEX_HEIGHT, 9'd1));
    rows.push_back(item_row(MODE_SAMPLE, 0, 0, 32'hFFFFFFFF, 32'h5555AAAA, 1, 0, 0));
    rows.push_back(cfg_row(REG_TEX_HEIGHT, 9'd0));
    rows.push_back(item_row(MODE_SAMPLE, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1, 0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(rows[i].idx[CFG_IDX_W-1:0], rows[i].val[8:0]);
      end else if (rows[i].mode == MODE_WRITE) begin
        send_beat(MODE_WRITE, rows[i].idx, rows[i].val, rows[i].u, rows[i].v, rows[i].bil,
                  0, 0);
      end else begin
        send_sample(rows[i].u, rows[i].v, rows[i].bil, rows[i].typed, rows[i].colour);
      end
    end

    for (int phase = 0; items_sent < 1380; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      sel = $urandom_range(9);
      if (phase % 4 == 0) set_dims(9'h100, 9'h100);
      else if (sel == 0) set_dims($urandom_range(1) ? 0 : $urandom_range(511),
                                  $urandom_range(1) ? 0 : $urandom_range(511));
      else if (sel == 1) set_dims($urandom_range(511, 256), $urandom_range(1, 4));
      else if (sel == 2) set_dims($urandom_range(1, 3), $urandom_range(257, 511));
      else set_dims($urandom_range(1, 9), $urandom_range(1, 9));
      // block fills while the receiver holds off
      if (phase == 2) hold_req = 1'b1;
      phase_items = (dim_w > 16 && dim_h > 16) ? 40 : 120;
      for (int n = 0; n < phase_items; n++) begin
        sel = $urandom_range(99);
        if (sel < 25) begin
          send_beat(MODE_WRITE, (sel < 20 && dim_w * dim_h > 0) ?
                    16'($urandom_range(dim_w * dim_h - 1)) : 16'($urandom),
                    $urandom, $urandom, $urandom, $urandom_range(1), 0, 0);
        end else begin
          u = $urandom;
          v = $urandom;
          if (sel < 30) u[15:0] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          else if (sel < 35) v[15:0] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          send_sample(u, v, $urandom_range(1), 0, 0);
        end
      end
    end

    settle();
    if (errors == 0 && colour_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
